/* rtl/ipsc_pkg.sv */
// ----------------------------------------------------------------------------
// ipsc_pkg
// Types, constants and the control store of the incremental PID speed loop.
// ----------------------------------------------------------------------------
package ipsc_pkg;

  // Field and datapath widths
  localparam int SPEED_W = 24;          // Q15.8 speed input
  localparam int ERR_W   = 25;          // Q.8 error and filtered error
  localparam int GAIN_W  = 32;          // Q15.16 gain
  localparam int LIM_W   = 16;          // dead band / output limit
  localparam int MUL_A_W = 33;          // multiplier operand A (gains, filter taps)
  localparam int MUL_B_W = 27;          // multiplier operand B (error terms)
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 62;          // product accumulator
  localparam int OUT_ACC_W = 32;        // output accumulator, Q16.16, never negative
  localparam int STEP_W  = 3;
  localparam int CFG_AW  = 5;

  // Low-pass filter taps, alpha = 0.9 in Q.16
  localparam logic [16:0] FILT_NEW = 17'd58982;
  localparam logic [16:0] FILT_OLD = 17'd6554;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [2:0] REG_GAIN_INTEG = 3'd1;
  localparam logic [2:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [2:0] REG_DEAD_BAND  = 3'd3;
  localparam logic [2:0] REG_OUTPUT_MAX = 3'd4;

  // Register reset values
  localparam logic [LIM_W-1:0] DEAD_BAND_RST  = 16'd1280;
  localparam logic [LIM_W-1:0] OUTPUT_MAX_RST = 16'd40000;

  // Program step numbers
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

  // Multiplier operand selects
  typedef enum logic [2:0] {
    A_FNEW,
    A_FOLD,
    A_KP,
    A_KI,
    A_KD
  } mula_sel_t;

  typedef enum logic [2:0] {
    B_ERR,
    B_LAST,
    B_DIFF1,
    B_FILT,
    B_DIFF2
  } mulb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // Sequencing of the step counter
  typedef enum logic [1:0] {
    SEQ_NEXT,      // go to next step
    SEQ_WAIT_IN,   // hold until an input transfer, then next
    SEQ_JMP_CLR,   // jump when the item is a clear, else next
    SEQ_WAIT_OUT   // hold until the output slot is free, then jump
  } seq_t;

  // One control word
  typedef struct packed {
    mula_sel_t          a_sel;
    mulb_sel_t          b_sel;
    acc_op_t            acc_op;
    logic               f_load;
    logic               finish;
    seq_t               seq;
    logic [STEP_W-1:0]  jump;
  } ctrl_t;

  // Control store
  function automatic ctrl_t ucode(logic [STEP_W-1:0] step);
    ctrl_t w;
    w.a_sel  = A_FNEW;
    w.b_sel  = B_ERR;
    w.acc_op = ACC_HOLD;
    w.f_load = 1'b0;
    w.finish = 1'b0;
    w.seq    = SEQ_NEXT;
    w.jump   = STEP_IDLE;
    case (step)
      3'd0: begin                      // wait for an item
        w.seq = SEQ_WAIT_IN;
      end
      3'd1: begin                      // acc = 58982 * e, clear skips ahead
        w.a_sel  = A_FNEW;
        w.b_sel  = B_ERR;
        w.acc_op = ACC_LOAD;
        w.seq    = SEQ_JMP_CLR;
        w.jump   = STEP_FINISH;
      end
      3'd2: begin                      // acc += 6554 * last
        w.a_sel  = A_FOLD;
        w.b_sel  = B_LAST;
        w.acc_op = ACC_ADD;
      end
      3'd3: begin                      // filtered error with dead band
        w.f_load = 1'b1;
      end
      3'd4: begin                      // acc = kp * (f - last)
        w.a_sel  = A_KP;
        w.b_sel  = B_DIFF1;
        w.acc_op = ACC_LOAD;
      end
      3'd5: begin                      // acc += ki * f
        w.a_sel  = A_KI;
        w.b_sel  = B_FILT;
        w.acc_op = ACC_ADD;
      end
      3'd6: begin                      // acc += kd * (f - 2*last + before)
        w.a_sel  = A_KD;
        w.b_sel  = B_DIFF2;
        w.acc_op = ACC_ADD;
      end
      3'd7: begin                      // update accumulator, post result
        w.finish = 1'b1;
        w.seq    = SEQ_WAIT_OUT;
        w.jump   = STEP_IDLE;
      end
      default: begin
        w.seq  = SEQ_WAIT_OUT;
        w.jump = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/ipsc_if.sv */
// ----------------------------------------------------------------------------
// ipsc_if
// Valid/ready channels of the speed loop: update items in, drive values out.
// ----------------------------------------------------------------------------
interface ipsc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [ipsc_pkg::SPEED_W-1:0] target_speed;
  logic signed [ipsc_pkg::SPEED_W-1:0] measured_speed;

  modport source (output valid, output action, output target_speed,
                  output measured_speed, input ready);
  modport sink   (input valid, input action, input target_speed,
                  input measured_speed, output ready);
endinterface

interface ipsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ipsc_pkg::LIM_W-1:0]  drive_value;
  logic                        clamped;

  modport source (output valid, output drive_value, output clamped, input ready);
  modport sink   (input valid, input drive_value, input clamped, output ready);
endinterface

/* rtl/incremental_pid_speed_control_top.sv */
// ----------------------------------------------------------------------------
// incremental_pid_speed_control_top
// Velocity-form PID speed loop with filtered error, dead band and output clamp.
// ----------------------------------------------------------------------------
// An update item is accepted only while the sequencer sits at its idle step and
// runs through the multiply, filter/dead-band and finish steps to a result in
// the output register; a clear item jumps from its first multiply step straight
// to the finish step. The next item can be accepted the cycle the sequencer
// returns to idle, so an item is never taken before the last one is through.
// The control program holds five multiply steps through the single shared
// 33x27 multiplier, one filter/dead-band step, one finish step and the idle step.
// Gains are signed Q15.16, speeds signed Q15.8; drive_value is the integer
// part of a Q16.16 accumulator held in [0, output_max].
// ----------------------------------------------------------------------------
module incremental_pid_speed_control_top (
  input  logic                             clk,
  input  logic                             rst_n,
  ipsc_in_if.sink                          in_chan,
  ipsc_out_if.source                       out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ipsc_pkg::CFG_AW-1:0]      paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // Configuration registers
  logic [ipsc_pkg::GAIN_W-1:0] gain_prop_r, gain_integ_r, gain_deriv_r;
  logic [ipsc_pkg::LIM_W-1:0]  dead_band_r, output_max_r;

  // Controller state
  logic signed [ipsc_pkg::ERR_W-1:0] last_r, before_r;
  logic [ipsc_pkg::OUT_ACC_W-1:0]    accum_r, accum_nxt;

  // Item and working registers
  logic signed [ipsc_pkg::ERR_W-1:0] err_r, err_nxt;
  logic                              clr_r;
  logic signed [ipsc_pkg::ERR_W-1:0] filt_r, filt_nxt;
  logic signed [ipsc_pkg::ACC_W-1:0] acc_r, acc_nxt;

  // Sequencer
  logic [ipsc_pkg::STEP_W-1:0] step_r, step_nxt;
  ipsc_pkg::ctrl_t             cw;
  logic                        in_xfer, fire;

  // Output register
  logic                        out_valid_r, out_valid_nxt;
  logic [ipsc_pkg::LIM_W-1:0]  out_drive_r;
  logic                        out_clamp_r, clamp_nxt;

  // Datapath
  logic signed [ipsc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [ipsc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ipsc_pkg::PROD_W-1:0]  prod;
  logic signed [ipsc_pkg::ERR_W:0]     diff1;
  logic signed [ipsc_pkg::MUL_B_W-1:0] diff2;
  logic signed [ipsc_pkg::ERR_W-1:0]   filt_raw;
  logic [ipsc_pkg::ERR_W-1:0]          filt_mag;
  logic signed [ipsc_pkg::ACC_W-9:0]   inc;
  logic signed [ipsc_pkg::ACC_W-8:0]   sum;
  logic [ipsc_pkg::OUT_ACC_W-1:0]      top;

  logic cfg_wr;

  // --------------------------------------------------------------------------
  // APB register file
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
      dead_band_r  <= ipsc_pkg::DEAD_BAND_RST;
      output_max_r <= ipsc_pkg::OUTPUT_MAX_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ipsc_pkg::REG_GAIN_PROP:  gain_prop_r  <= pwdata;
        ipsc_pkg::REG_GAIN_INTEG: gain_integ_r <= pwdata;
        ipsc_pkg::REG_GAIN_DERIV: gain_deriv_r <= pwdata;
        ipsc_pkg::REG_DEAD_BAND:  dead_band_r  <= pwdata[15:0];
        ipsc_pkg::REG_OUTPUT_MAX: output_max_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (paddr[4:2])
      ipsc_pkg::REG_GAIN_PROP:  prdata = gain_prop_r;
      ipsc_pkg::REG_GAIN_INTEG: prdata = gain_integ_r;
      ipsc_pkg::REG_GAIN_DERIV: prdata = gain_deriv_r;
      ipsc_pkg::REG_DEAD_BAND:  prdata = {16'b0, dead_band_r};
      ipsc_pkg::REG_OUTPUT_MAX: prdata = {16'b0, output_max_r};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter and control store
  // --------------------------------------------------------------------------
  assign cw             = ipsc_pkg::ucode(step_r);
  assign in_chan.ready  = (step_r == ipsc_pkg::STEP_IDLE);
  assign in_xfer        = in_chan.valid && in_chan.ready;

  always_comb begin
    step_nxt = step_r;
    fire     = 1'b0;
    case (cw.seq)
      ipsc_pkg::SEQ_NEXT:    step_nxt = step_r + 3'd1;
      ipsc_pkg::SEQ_WAIT_IN: begin
        if (in_xfer) step_nxt = step_r + 3'd1;
      end
      ipsc_pkg::SEQ_JMP_CLR: step_nxt = clr_r ? cw.jump : step_r + 3'd1;
      ipsc_pkg::SEQ_WAIT_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          step_nxt = cw.jump;
          fire     = cw.finish;
        end
      end
      default: step_nxt = ipsc_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_r <= ipsc_pkg::STEP_IDLE;
    else        step_r <= step_nxt;
  end

  // --------------------------------------------------------------------------
  // Item capture: raw error and item kind
  // --------------------------------------------------------------------------
  assign err_nxt = {in_chan.target_speed[23], in_chan.target_speed}
                 - {in_chan.measured_speed[23], in_chan.measured_speed};

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r <= err_nxt;
      clr_r <= in_chan.action;
    end
  end

  // --------------------------------------------------------------------------
  // Error differences for the P and D terms
  // --------------------------------------------------------------------------
  assign diff1 = {filt_r[24], filt_r} - {last_r[24], last_r};
  assign diff2 = {{2{filt_r[24]}}, filt_r} - {last_r[24], last_r, 1'b0}
               + {{2{before_r[24]}}, before_r};

  // --------------------------------------------------------------------------
  // Shared multiplier and accumulator
  // --------------------------------------------------------------------------
  always_comb begin
    case (cw.a_sel)
      ipsc_pkg::A_FNEW: mul_a = $signed({16'b0, ipsc_pkg::FILT_NEW});
      ipsc_pkg::A_FOLD: mul_a = $signed({16'b0, ipsc_pkg::FILT_OLD});
      ipsc_pkg::A_KP:   mul_a = $signed({gain_prop_r[31], gain_prop_r});
      ipsc_pkg::A_KI:   mul_a = $signed({gain_integ_r[31], gain_integ_r});
      ipsc_pkg::A_KD:   mul_a = $signed({gain_deriv_r[31], gain_deriv_r});
      default:          mul_a = '0;
    endcase
    case (cw.b_sel)
      ipsc_pkg::B_ERR:   mul_b = {{2{err_r[24]}}, err_r};
      ipsc_pkg::B_LAST:  mul_b = {{2{last_r[24]}}, last_r};
      ipsc_pkg::B_DIFF1: mul_b = {diff1[25], diff1};
      ipsc_pkg::B_FILT:  mul_b = {{2{filt_r[24]}}, filt_r};
      ipsc_pkg::B_DIFF2: mul_b = diff2;
      default:           mul_b = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    case (cw.acc_op)
      ipsc_pkg::ACC_LOAD: acc_nxt = {{2{prod[59]}}, prod};
      ipsc_pkg::ACC_ADD:  acc_nxt = acc_r + {{2{prod[59]}}, prod};
      default:            acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // --------------------------------------------------------------------------
  // Filtered error: floor(acc / 2^16), zeroed inside the dead band
  // --------------------------------------------------------------------------
  assign filt_raw = acc_r[40:16];
  assign filt_mag = filt_raw[24] ? 25'(-filt_raw) : filt_raw;
  assign filt_nxt = (filt_mag < {9'b0, dead_band_r}) ? '0 : filt_raw;

  always_ff @(posedge clk) begin
    if (cw.f_load) filt_r <= filt_nxt;
  end

  // --------------------------------------------------------------------------
  // Finish: clear, or add increment and clamp to [0, output_max]
  // --------------------------------------------------------------------------
  assign inc = acc_r[61:8];
  assign sum = $signed({23'b0, accum_r}) + $signed({inc[53], inc});
  assign top = {output_max_r, 16'b0};

  always_comb begin
    clamp_nxt = 1'b0;
    if (clr_r) begin
      accum_nxt = '0;
    end else if (sum < 0) begin
      accum_nxt = '0;
      clamp_nxt = 1'b1;
    end else if (sum > $signed({23'b0, top})) begin
      accum_nxt = top;
      clamp_nxt = 1'b1;
    end else begin
      accum_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r  <= '0;
      last_r   <= '0;
      before_r <= '0;
    end else if (fire) begin
      accum_r <= accum_nxt;
      if (!clr_r) begin
        before_r <= last_r;
        last_r   <= filt_r;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_comb begin
    if (fire)                 out_valid_nxt = 1'b1;
    else if (out_chan.ready)  out_valid_nxt = 1'b0;
    else                      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_drive_r <= accum_nxt[31:16];
      out_clamp_r <= clamp_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.drive_value = out_drive_r;
  assign out_chan.clamped     = out_clamp_r;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the incremental PID speed loop. A directed table
// covers reset values, extreme speeds, clears, both clamps, the dead band and
// floor rounding. Randomized phases with fresh gains and limits follow. Each
// result is checked against a pinned value or a bit-accurate control-law model.
// ----------------------------------------------------------------------------
module testbench;

  // Item codes and bench constants
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic [ipsc_pkg::SPEED_W-1:0] SPD_MAX = 24'h7FFFFF;
  localparam logic [ipsc_pkg::SPEED_W-1:0] SPD_MIN = 24'h800000;
  localparam logic [ipsc_pkg::SPEED_W-1:0] SPD_ONE = 24'h000100;   // 1.0 RPM
  localparam logic [ipsc_pkg::GAIN_W-1:0]  GAIN_MAX = 32'h7FFFFFFF;
  localparam logic [ipsc_pkg::GAIN_W-1:0]  GAIN_MIN = 32'h80000000;
  localparam logic [ipsc_pkg::GAIN_W-1:0]  GAIN_ONE = 32'h00010000;

  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLDOFF_PHASE   = 2;
  localparam int OPEN_PHASE      = 5;
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int LATENCY         = 8;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_REPORTS     = 10;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [ipsc_pkg::LIM_W-1:0] drive;
    logic                       clamped;
  } drive_result_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic                         action;
    logic [ipsc_pkg::SPEED_W-1:0] tgt;
    logic [ipsc_pkg::SPEED_W-1:0] meas;
    logic [2:0]                   reg_idx;
    logic [31:0]                  value;
    logic                         pinned;
    logic [ipsc_pkg::LIM_W-1:0]   drive;
    logic                         clamped;
  } stim_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [ipsc_pkg::CFG_AW-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  ipsc_in_if  in_chan ();
  ipsc_out_if out_chan ();

  incremental_pid_speed_control_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Predictor copy of the registers and the loop state
  logic signed [ipsc_pkg::GAIN_W-1:0] gain_p;
  logic signed [ipsc_pkg::GAIN_W-1:0] gain_i;
  logic signed [ipsc_pkg::GAIN_W-1:0] gain_d;
  logic [ipsc_pkg::LIM_W-1:0]         band;
  logic [ipsc_pkg::LIM_W-1:0]         drive_max;
  longint                             filt_last;
  longint                             filt_prev;
  longint                             drive_accum;

  drive_result_t pending_drives[$];
  stim_row_t     stim_rows[$];

  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  clears_sent;
  int  cfg_writes;
  int  burst_left;
  bit  no_idle;
  bit  holdoff_req;
  bit  holdoff_done;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Control law: filter, dead band, PID increment, clamp; a clear zeroes the drive
  function automatic drive_result_t predict_drive(
      input logic action,
      input logic signed [ipsc_pkg::SPEED_W-1:0] tgt,
      input logic signed [ipsc_pkg::SPEED_W-1:0] meas);
    drive_result_t r;
    longint        err;
    longint        filt;
    longint        mag;
    longint        step;
    longint        top;
    r.drive   = '0;
    r.clamped = 1'b0;
    if (action == ACT_CLEAR) begin
      // error history survives a clear
      drive_accum = 0;
      return r;
    end
    err  = longint'(tgt) - longint'(meas);
    filt = (longint'(ipsc_pkg::FILT_NEW) * err
          + longint'(ipsc_pkg::FILT_OLD) * filt_last) >>> 16;
    mag  = (filt < 0) ? -filt : filt;
    if (mag < longint'(band)) filt = 0;
    step = longint'(gain_p) * (filt - filt_last)
         + longint'(gain_i) * filt
         + longint'(gain_d) * (filt - 2 * filt_last + filt_prev);
    step = step >>> 8;
    filt_prev = filt_last;
    filt_last = filt;
    drive_accum += step;
    top = longint'(drive_max) << 16;
    if (drive_accum < 0) begin
      drive_accum = 0;
      r.clamped   = 1'b1;
    end else if (drive_accum > top) begin
      drive_accum = top;
      r.clamped   = 1'b1;
    end
    r.drive = drive_accum[31:16];
    return r;
  endfunction

  // Directed table rows
  function automatic stim_row_t item_row(input logic action,
                                         input logic [ipsc_pkg::SPEED_W-1:0] tgt,
                                         input logic [ipsc_pkg::SPEED_W-1:0] meas);
    stim_row_t row;
    row        = '0;
    row.kind   = ROW_ITEM;
    row.action = action;
    row.tgt    = tgt;
    row.meas   = meas;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input logic action,
                                           input logic [ipsc_pkg::SPEED_W-1:0] tgt,
                                           input logic [ipsc_pkg::SPEED_W-1:0] meas,
                                           input logic [ipsc_pkg::LIM_W-1:0] drive,
                                           input logic clamped);
    stim_row_t row;
    row         = item_row(action, tgt, meas);
    row.pinned  = 1'b1;
    row.drive   = drive;
    row.clamped = clamped;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [2:0] idx, input logic [31:0] value);
    stim_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.reg_idx = idx;
    row.value   = value;
    return row;
  endfunction

  // Random register values, extremes included
  function automatic logic [31:0] rand_gain();
    int k;
    k = $urandom_range(8, 20);
    case ($urandom_range(0, 7))
      0:       return GAIN_MAX;
      1:       return GAIN_MIN;
      2:       return '0;
      default: return int'($urandom_range(0, 2 << k)) - (1 << k);
    endcase
  endfunction

  function automatic logic [31:0] rand_limit(input logic [ipsc_pkg::LIM_W-1:0] typical);
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd65535;
      2:       return 32'd1;
      3:       return $urandom_range(0, 65535);
      4:       return $urandom_range(0, 2047);
      default: return {16'd0, typical};
    endcase
  endfunction

  // APB write, then read back through the same select
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask    = (idx <= ipsc_pkg::REG_GAIN_DERIV) ? 32'hFFFFFFFF : 32'h0000FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      ipsc_pkg::REG_GAIN_PROP:  gain_p    = value;
      ipsc_pkg::REG_GAIN_INTEG: gain_i    = value;
      ipsc_pkg::REG_GAIN_DERIV: gain_d    = value;
      ipsc_pkg::REG_DEAD_BAND:  band      = value[ipsc_pkg::LIM_W-1:0];
      ipsc_pkg::REG_OUTPUT_MAX: drive_max = value[ipsc_pkg::LIM_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("ERROR: register %0d reads 0x%08h, wrote 0x%08h", idx, prdata, value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item in a burst pattern, predict it on transfer
  task automatic send_item(input logic action, input logic [ipsc_pkg::SPEED_W-1:0] tgt,
                           input logic [ipsc_pkg::SPEED_W-1:0] meas, input logic pinned,
                           input drive_result_t typed);
    int            gap;
    drive_result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_idle) gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.action         <= action;
    in_chan.target_speed   <= tgt;
    in_chan.measured_speed <= meas;
    in_chan.valid          <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    predicted = predict_drive(action, tgt, meas);
    pending_drives.push_back(pinned ? typed : predicted);
    items_sent++;
    if (action == ACT_CLEAR) clears_sent++;
  endtask

  task automatic wait_drained();
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  // Receiver: changing stall pattern plus one long hold-off
  initial begin
    int       cycle;
    int       held;
    rx_mode_t rx_mode;
    out_chan.ready = 1'b0;
    cycle   = 0;
    held    = 0;
    rx_mode = RX_OPEN;
    forever begin
      @(posedge clk);
      cycle++;
      if (cycle % 64 == 0)
        rx_mode = no_idle ? RX_OPEN : rx_mode_t'($urandom_range(0, 2));
      if (holdoff_req && !holdoff_done) begin
        out_chan.ready <= 1'b0;
        held++;
        if (held == HOLDOFF_CYCLES) holdoff_done = 1'b1;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_chan.ready <= 1'b1;
          RX_RANDOM: out_chan.ready <= ($urandom_range(0, 1) == 0);
          default:   out_chan.ready <= (cycle % 4 == 0);
        endcase
      end
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready) begin
      results_seen++;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result drive=%0d clamped=%0b",
                   out_chan.drive_value, out_chan.clamped);
      end else begin
        want = pending_drives.pop_front();
        if (out_chan.drive_value !== want.drive || out_chan.clamped !== want.clamped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("ERROR: result %0d: drive exp %0d got %0d, clamped exp %0b got %0b",
                     results_seen, want.drive, out_chan.drive_value,
                     want.clamped, out_chan.clamped);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    drive_result_t                typed;
    logic                         action;
    logic [ipsc_pkg::SPEED_W-1:0] tgt;
    logic [ipsc_pkg::SPEED_W-1:0] meas;
    logic [31:0]                  rnd;
    logic [31:0]                  delta;
    int                           k;

    rst_n                  = 1'b0;
    in_chan.valid          = 1'b0;
    in_chan.action         = ACT_UPDATE;
    in_chan.target_speed   = '0;
    in_chan.measured_speed = '0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    clears_sent  = 0;
    cfg_writes   = 0;
    burst_left   = 0;
    no_idle      = 1'b0;
    holdoff_req  = 1'b0;
    holdoff_done = 1'b0;
    gain_p       = '0;
    gain_i       = '0;
    gain_d       = '0;
    band         = ipsc_pkg::DEAD_BAND_RST;
    drive_max    = ipsc_pkg::OUTPUT_MAX_RST;
    filt_last    = 0;
    filt_prev    = 0;
    drive_accum  = 0;

    // Reset values: zero gains keep the drive at zero
    stim_rows.push_back(pinned_row(ACT_UPDATE, 24'd0, 24'd0, 16'd0, 1'b0));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, SPD_MIN, 16'd0, 1'b0));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MIN, SPD_MAX, 16'd0, 1'b0));
    stim_rows.push_back(pinned_row(ACT_CLEAR, SPD_MAX, SPD_MAX, 16'd0, 1'b0));
    // Full positive integral gain drives into the upper clamp
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_INTEG, GAIN_MAX));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, 24'd0, 16'd40000, 1'b1));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, 24'd0, 16'd40000, 1'b1));
    // Full negative gain drives into the lower clamp
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_INTEG, GAIN_MIN));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, 24'd0, 16'd0, 1'b1));
    stim_rows.push_back(pinned_row(ACT_CLEAR, 24'd0, 24'd0, 16'd0, 1'b0));
    // Zero output limit, then full output limit
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_OUTPUT_MAX, 32'd0));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_INTEG, GAIN_MAX));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, 24'd0, 16'd0, 1'b1));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_OUTPUT_MAX, 32'd65535));
    stim_rows.push_back(pinned_row(ACT_UPDATE, SPD_MAX, SPD_MIN, 16'd65535, 1'b1));
    stim_rows.push_back(pinned_row(ACT_CLEAR, 24'd0, 24'd0, 16'd0, 1'b0));
    // Widest dead band lets the error history decay to zero
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_DEAD_BAND, 32'd65535));
    repeat (4) stim_rows.push_back(item_row(ACT_UPDATE, 24'd0, 24'd0));
    // No dead band, tiny gain: floor rounding into the lower clamp
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_DEAD_BAND, 32'd0));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_INTEG, 32'd1));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_OUTPUT_MAX, 32'd1));
    stim_rows.push_back(item_row(ACT_CLEAR, 24'd0, 24'd0));
    stim_rows.push_back(item_row(ACT_UPDATE, 24'hFFFFFF, 24'd0));
    // Unit gain: accumulate past a limit of one count by a fraction
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_INTEG, GAIN_ONE));
    stim_rows.push_back(item_row(ACT_UPDATE, SPD_ONE, 24'd0));
    stim_rows.push_back(item_row(ACT_UPDATE, SPD_ONE, 24'd0));
    stim_rows.push_back(item_row(ACT_UPDATE, 24'd0, SPD_ONE));
    // All three terms with extreme gains at reset limits
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_PROP, GAIN_MAX));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_GAIN_DERIV, GAIN_MIN));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_DEAD_BAND, {16'd0, ipsc_pkg::DEAD_BAND_RST}));
    stim_rows.push_back(cfg_row(ipsc_pkg::REG_OUTPUT_MAX, {16'd0, ipsc_pkg::OUTPUT_MAX_RST}));
    stim_rows.push_back(item_row(ACT_UPDATE, SPD_MAX, SPD_MIN));
    stim_rows.push_back(item_row(ACT_UPDATE, SPD_MIN, SPD_MAX));
    stim_rows.push_back(item_row(ACT_CLEAR, 24'd0, 24'd0));
    stim_rows.push_back(item_row(ACT_UPDATE, 24'h001000, 24'h000F00));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        in_chan.valid <= 1'b0;
        wait_drained();
        cfg_write(stim_rows[i].reg_idx, stim_rows[i].value);
      end else begin
        typed.drive   = stim_rows[i].drive;
        typed.clamped = stim_rows[i].clamped;
        send_item(stim_rows[i].action, stim_rows[i].tgt, stim_rows[i].meas,
                  stim_rows[i].pinned, typed);
      end
    end
    in_chan.valid <= 1'b0;
    wait_drained();

    // Random phases, each with fresh register settings
    typed = '0;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      no_idle = (phase == OPEN_PHASE);
      cfg_write(ipsc_pkg::REG_GAIN_PROP, rand_gain());
      cfg_write(ipsc_pkg::REG_GAIN_INTEG, rand_gain());
      cfg_write(ipsc_pkg::REG_GAIN_DERIV, rand_gain());
      cfg_write(ipsc_pkg::REG_DEAD_BAND, rand_limit(ipsc_pkg::DEAD_BAND_RST));
      cfg_write(ipsc_pkg::REG_OUTPUT_MAX, rand_limit(ipsc_pkg::OUTPUT_MAX_RST));
      if (phase == HOLDOFF_PHASE) holdoff_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        action = ($urandom_range(0, 15) == 0) ? ACT_CLEAR : ACT_UPDATE;
        rnd    = $urandom;
        tgt    = rnd[ipsc_pkg::SPEED_W-1:0];
        if ($urandom_range(0, 3) == 0) begin
          rnd  = $urandom;
          meas = rnd[ipsc_pkg::SPEED_W-1:0];
        end else begin
          // measured speed tracks the target within a random window
          k     = $urandom_range(0, 16);
          delta = int'($urandom_range(0, 2 << k)) - (1 << k);
          meas  = tgt - delta[ipsc_pkg::SPEED_W-1:0];
        end
        send_item(action, tgt, meas, 1'b0, typed);
      end
      in_chan.valid <= 1'b0;
      wait_drained();
    end

    // Let any stray result show up
    repeat (2 * LATENCY) @(posedge clk);
    mismatches += pending_drives.size();

    $display("Ran %0d items (%0d clears) through %0d register writes; %0d results checked.",
             items_sent, clears_sent, cfg_writes, results_seen);
    $display("Output held off for %0d cycles once; %0d mismatches.", HOLDOFF_CYCLES,
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
